>>> design/drc_pkg.sv
// Package for the dirty bitmap run coalescer: widths, codes, controller types
// and the command and status structs between controller and datapath.
// Depends on nothing.
`default_nettype none
package drc_pkg;

  localparam int WORD_BITS   = 32;
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int WC_W        = 15;
  localparam int CELL_W      = WC_W + BIT_W;
  localparam int COUNT_W     = CELL_W + 1;
  localparam int MAX_COLUMNS = 1024;
  localparam int ROW_LIMIT   = 1024;
  localparam int DIM_W       = 11;
  localparam int COL_W       = 10;
  localparam int ROW_W       = 10;
  localparam int LEN_W       = 11;
  localparam int COLOR_W     = 16;
  localparam int ACT_W       = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int S_TDATA_W = 3 * WORD_BITS;
  localparam int S_TUSER_W = ACT_W + 1;
  localparam int M_TDATA_W = 48;

  localparam int DIV_STEPS = CELL_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIM        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 3'd4;

  // Action codes carried with every input word.
  localparam logic [ACT_W-1:0] ACT_DIRTY  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DIM    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_BRIGHT = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_BASE,
    ST_BASE_WAIT,
    ST_SCAN,
    ST_FLUSH,
    ST_EMIT_WAIT,
    ST_FIN
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RET_BASE,
    RET_SCAN,
    RET_FIN
  } ret_state_e;

  typedef struct packed {
    logic in_load;
    logic prep;
    logic div_start;
    logic div_sel_run;
    logic base_load;
    logic scan_take;
    logic scan_adv;
    logic pend_load;
    logic fin_push;
  } drc_cmd_t;

  typedef struct packed {
    logic in_skip;
    logic div_done;
    logic pend_free;
    logic run_open;
    logic item_first;
    logic item_last;
    logic bit_set;
    logic bit_past;
    logic bit_split;
    logic bit_final;
  } drc_sts_t;

endpackage
`default_nettype wire

>>> design/drc_divider.sv
// Restoring divider, one quotient bit per cycle, for cell index to row/column.
// Depends on drc_pkg.
`default_nettype none
module drc_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [drc_pkg::CELL_W-1:0]  dividend_i,
  input  logic [drc_pkg::DIM_W-1:0]   divisor_i,
  output logic                        busy_o,
  output logic [drc_pkg::CELL_W-1:0]  quot_o,
  output logic [drc_pkg::DIM_W-1:0]   rem_o
);
  import drc_pkg::*;

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [CELL_W-1:0]    quot_q;
  logic [DIM_W-1:0]     rem_q;
  logic [DIM_W-1:0]     dvs_q;
  logic [DIM_W:0]       shifted;
  logic [DIM_W:0]       diff;
  logic                 qbit;

  assign shifted = {rem_q, quot_q[CELL_W-1]};
  assign qbit    = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[CELL_W-2:0], qbit};
      rem_q  <= qbit ? diff[DIM_W-1:0] : shifted[DIM_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

>>> design/drc_datapath.sv
// Datapath of the run coalescer: configuration, item and run registers, bit scan,
// pending result and output register. Depends on drc_pkg and drc_divider.
`default_nettype none
module drc_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [drc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [drc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [drc_pkg::S_TDATA_W-1:0]  s_tdata_i,
  input  logic [drc_pkg::S_TUSER_W-1:0]  s_tuser_i,
  input  logic                           s_tlast_i,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [drc_pkg::M_TDATA_W-1:0]  m_tdata_o,
  output logic                           m_tlast_o,
  input  drc_pkg::drc_cmd_t              cmd_i,
  output drc_pkg::drc_sts_t              sts_o
);
  import drc_pkg::*;

  // Configuration registers.
  logic [DIM_W-1:0]   cols_q, rows_q;
  logic [COLOR_W-1:0] bright_q, dimc_q, bg_q;

  // Current item.
  logic [ACT_W-1:0]     act_q;
  logic [WORD_BITS-1:0] chg_q, lit_q, dimb_q;
  logic                 first_q, last_q;

  // Block state.
  logic [WC_W-1:0]    wc_q;
  logic               run_open_q;
  logic [CELL_W-1:0]  run_start_q, run_end_q;
  logic [COLOR_W-1:0] open_color_q;
  logic [COUNT_W-1:0] cell_count_q;
  logic [BIT_W-1:0]   b_q;
  logic [COL_W-1:0]   col_q;

  // Pending result and output register.
  logic               pend_valid_q;
  logic [COL_W-1:0]   pend_col_q;
  logic [ROW_W-1:0]   pend_row_q;
  logic [LEN_W-1:0]   pend_len_q;
  logic [COLOR_W-1:0] pend_color_q;
  logic               out_valid_q;
  logic               out_last_q;
  logic [COL_W-1:0]   out_col_q;
  logic [ROW_W-1:0]   out_row_q;
  logic [LEN_W-1:0]   out_len_q;
  logic [COLOR_W-1:0] out_color_q;

  logic [DIM_W-1:0]     eff_cols, eff_rows, divisor;
  logic [2*DIM_W-1:0]   cell_prod;
  logic [CELL_W-1:0]    idx, dividend, run_span;
  logic [COUNT_W-1:0]   end_next;
  logic [COLOR_W-1:0]   color;
  logic                 col_wrap;
  logic                 out_free, push;
  logic                 div_busy;
  logic [CELL_W-1:0]    div_quot;
  logic [DIM_W-1:0]     div_rem;

  assign eff_cols  = (cols_q > DIM_W'(MAX_COLUMNS)) ? DIM_W'(MAX_COLUMNS) : cols_q;
  assign eff_rows  = (rows_q > DIM_W'(ROW_LIMIT)) ? DIM_W'(ROW_LIMIT) : rows_q;
  assign divisor   = (eff_cols == '0) ? DIM_W'(1) : eff_cols;
  assign cell_prod = eff_cols * eff_rows;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q   <= DIM_W'(1);
      rows_q   <= DIM_W'(1);
      bright_q <= '1;
      dimc_q   <= '0;
      bg_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_COLUMNS:    cols_q   <= cfg_wdata_i[DIM_W-1:0];
        REG_ROWS:       rows_q   <= cfg_wdata_i[DIM_W-1:0];
        REG_BRIGHT:     bright_q <= cfg_wdata_i[COLOR_W-1:0];
        REG_DIM:        dimc_q   <= cfg_wdata_i[COLOR_W-1:0];
        REG_BACKGROUND: bg_q     <= cfg_wdata_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      act_q   <= s_tuser_i[ACT_W-1:0];
      first_q <= s_tuser_i[ACT_W];
      last_q  <= s_tlast_i;
      chg_q   <= s_tdata_i[WORD_BITS-1:0];
      lit_q   <= s_tdata_i[2*WORD_BITS-1:WORD_BITS];
      dimb_q  <= s_tdata_i[3*WORD_BITS-1:2*WORD_BITS];
    end
    if (cmd_i.prep) begin
      cell_count_q <= cell_prod[COUNT_W-1:0];
    end
  end

  // Scan of the bit under the cursor. The cell index is the word count with
  // the bit position appended, as a word holds a power of two of cells.
  assign idx      = {wc_q, b_q};
  assign end_next = {1'b0, run_end_q} + COUNT_W'(1);
  assign col_wrap = ({1'b0, col_q} + DIM_W'(1)) == divisor;
  assign run_span = run_end_q - run_start_q + CELL_W'(1);
  assign dividend = cmd_i.div_sel_run ? run_start_q : {wc_q, {BIT_W{1'b0}}};

  always_comb begin
    case (act_q)
      ACT_DIRTY: color = lit_q[b_q] ? bright_q : (dimb_q[b_q] ? dimc_q : bg_q);
      ACT_DIM:   color = dimc_q;
      default:   color = bright_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q         <= '0;
      run_open_q   <= 1'b0;
      run_start_q  <= '0;
      run_end_q    <= '0;
      open_color_q <= '0;
      b_q          <= '0;
      col_q        <= '0;
    end else begin
      if (cmd_i.prep && first_q) begin
        wc_q <= '0;
      end else if (cmd_i.fin_push) begin
        wc_q <= wc_q + WC_W'(1);
      end
      if (cmd_i.base_load) begin
        b_q   <= '0;
        col_q <= div_rem[COL_W-1:0];
      end else if (cmd_i.scan_adv) begin
        b_q   <= b_q + BIT_W'(1);
        col_q <= col_wrap ? '0 : col_q + COL_W'(1);
      end
      if (cmd_i.pend_load) begin
        run_open_q <= 1'b0;
      end else if (cmd_i.scan_take) begin
        if (!run_open_q) begin
          run_open_q   <= 1'b1;
          run_start_q  <= idx;
          open_color_q <= color;
        end
        run_end_q <= idx;
      end
    end
  end

  // A finished run waits in the pending register until the next one arrives
  // or the word is finished, so that the final run of a word can be marked.
  assign out_free = !out_valid_q || m_tready_i;
  assign push     = (cmd_i.pend_load || cmd_i.fin_push) && pend_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.pend_load) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.fin_push) begin
        pend_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_load) begin
      pend_col_q   <= div_rem[COL_W-1:0];
      pend_row_q   <= div_quot[ROW_W-1:0];
      pend_len_q   <= run_span[LEN_W-1:0];
      pend_color_q <= open_color_q;
    end
    if (push) begin
      out_col_q   <= pend_col_q;
      out_row_q   <= pend_row_q;
      out_len_q   <= pend_len_q;
      out_color_q <= pend_color_q;
      out_last_q  <= cmd_i.fin_push;
    end
  end

  drc_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign m_tvalid_o = out_valid_q;
  assign m_tlast_o  = out_last_q;
  assign m_tdata_o  = {1'b0, out_color_q, out_len_q, out_row_q, out_col_q};

  assign sts_o.in_skip    = s_tuser_i[ACT_W-1:0] == ACT_NONE;
  assign sts_o.div_done   = !div_busy;
  assign sts_o.pend_free  = !pend_valid_q || out_free;
  assign sts_o.run_open   = run_open_q;
  assign sts_o.item_first = first_q;
  assign sts_o.item_last  = last_q;
  assign sts_o.bit_set    = chg_q[b_q];
  assign sts_o.bit_past   = {1'b0, idx} >= cell_count_q;
  assign sts_o.bit_split  = run_open_q &&
                            (({1'b0, idx} != end_next) || (col_q == '0) ||
                             (color != open_color_q));
  assign sts_o.bit_final  = b_q == BIT_W'(WORD_BITS - 1);

endmodule
`default_nettype wire

>>> design/drc_ctrl.sv
// Controller state machine of the run coalescer: sequences prepare, base
// division, bit scan, run emission and item finish. Depends on drc_pkg.
`default_nettype none
module drc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  drc_pkg::drc_sts_t sts_i,
  output drc_pkg::drc_cmd_t cmd_o
);
  import drc_pkg::*;

  ctrl_state_e state_q, state_d;
  ret_state_e  ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= RET_BASE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i && !sts_i.in_skip) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        if (sts_i.item_first && sts_i.run_open) begin
          ret_d   = RET_BASE;
          state_d = ST_EMIT_WAIT;
        end else begin
          state_d = ST_BASE;
        end
      end
      ST_BASE: state_d = ST_BASE_WAIT;
      ST_BASE_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts_i.bit_set) begin
          if (sts_i.bit_final) begin
            state_d = ST_FLUSH;
          end
        end else if (sts_i.bit_past) begin
          state_d = ST_FLUSH;
        end else if (sts_i.bit_split) begin
          ret_d   = RET_SCAN;
          state_d = ST_EMIT_WAIT;
        end else if (sts_i.bit_final) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (sts_i.item_last && sts_i.run_open) begin
          ret_d   = RET_FIN;
          state_d = ST_EMIT_WAIT;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_EMIT_WAIT: begin
        if (sts_i.div_done && sts_i.pend_free) begin
          case (ret_q)
            RET_BASE: state_d = ST_BASE;
            RET_SCAN: state_d = ST_SCAN;
            default:  state_d = ST_FIN;
          endcase
        end
      end
      ST_FIN: begin
        if (sts_i.pend_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o    = 1'b1;
        cmd_o.in_load = s_tvalid_i;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        if (sts_i.item_first && sts_i.run_open) begin
          cmd_o.div_start   = 1'b1;
          cmd_o.div_sel_run = 1'b1;
        end
      end
      ST_BASE: cmd_o.div_start = 1'b1;
      ST_BASE_WAIT: cmd_o.base_load = sts_i.div_done;
      ST_SCAN: begin
        if (!sts_i.bit_set) begin
          cmd_o.scan_adv = 1'b1;
        end else if (!sts_i.bit_past) begin
          if (sts_i.bit_split) begin
            cmd_o.div_start   = 1'b1;
            cmd_o.div_sel_run = 1'b1;
          end else begin
            cmd_o.scan_take = 1'b1;
            cmd_o.scan_adv  = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (sts_i.item_last && sts_i.run_open) begin
          cmd_o.div_start   = 1'b1;
          cmd_o.div_sel_run = 1'b1;
        end
      end
      ST_EMIT_WAIT: cmd_o.pend_load = sts_i.div_done && sts_i.pend_free;
      ST_FIN: cmd_o.fin_push = sts_i.pend_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> design/dirty_bitmap_run_coalescer.sv
// Dirty bitmap run coalescer, top level. Each input word passes through setup,
// a division for the column of the word's first cell and a bit scan, and
// every run emitted adds a division by the shared bit-serial divider that
// turns the run's first cell into row and column. The last run of a word
// moves through the pending register and then the output register to the output.
// Reset is asynchronous, active low, and restores configuration and state defaults.
`default_nettype none
module dirty_bitmap_run_coalescer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [drc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [drc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Input words.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata, lowest bit up: change_bits[31:0], lit_bits[63:32], dim_bits[95:64]
  input  logic [drc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // tuser, lowest bit up: action[1:0], first_word[2]
  input  logic [drc_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  // tlast carries last_word
  input  logic                           s_axis_tlast,
  // Output runs.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata, lowest bit up: run_column[9:0], run_row[19:10], run_length[30:20],
  // run_color[46:31], zero pad[47]
  output logic [drc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // tlast carries last_of_word
  output logic                           m_axis_tlast
);
  import drc_pkg::*;

  // The controller walks each accepted word through prepare, base division,
  // the scan of its bits from lowest to highest and the final flush. A run is
  // closed when the next set cell is not adjacent, starts a row, or changes
  // colour; its first cell is then divided by the column count to give row
  // and column. Closed runs wait in a pending register, so the last run of a
  // word can carry tlast, and then move to the output register, which lets
  // the next word be taken while a result still waits for its transfer.
  // Words with the unused action code are taken and dropped at once.

  drc_cmd_t cmd;
  drc_sts_t sts;

  drc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  drc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .s_tlast_i   (s_axis_tlast),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tlast_o   (m_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

`ifndef NO_ASSERTIONS
  // The divider is never restarted while it is still working.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> sts.div_done)
    else $error("divider restarted while busy");

  // A closed run is only stored once its division is done and room exists.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pend_load |-> (sts.div_done && sts.pend_free && sts.run_open))
    else $error("run stored without result or room");

  // Finishing a word never drops the pending run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin_push |-> sts.pend_free)
    else $error("word finished with pending run blocked");

  // A word with the unused action leaves the block ready for the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] == ACT_NONE))
      |=> s_axis_tready)
    else $error("dropped word did not return to ready");
`endif

endmodule
`default_nettype wire
